FILE: hdl/slice_spec_parser_defines.svh
// ----------------------------------------------------------------------------
// Slice spec parser assertion macros
// Shorthand for clocked assertions that are disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef SLICE_SPEC_PARSER_DEFINES_SVH
`define SLICE_SPEC_PARSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// Slice spec parser package
// Character codes, token status types, error codes and token helpers.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int OUT_VALUE_BITS = 32;

  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_COLONS   = 3'd1,
    ERR_LOWER    = 3'd2,
    ERR_UPPER    = 3'd3,
    ERR_STRIDE   = 3'd4,
    ERR_SINGLE   = 3'd5,
    ERR_OVERFLOW = 3'd6
  } err_t;

  typedef enum logic [1:0] {
    TK_LEAD   = 2'd0,
    TK_SIGN   = 2'd1,
    TK_DIGITS = 2'd2,
    TK_BAD    = 2'd3
  } tok_state_t;

  typedef enum logic [1:0] {
    LONE_NONE = 2'd0,
    LONE_STAR = 2'd1,
    LONE_HASH = 2'd2
  } lone_t;

  // Edge trimming phase
  typedef enum logic [2:0] {
    PH_BRACKET = 3'b001,
    PH_SPACE   = 3'b010,
    PH_CORE    = 3'b100
  } phase_t;

  typedef struct packed {
    logic       ovf;
    lone_t      lone;
    logic       nonempty;
    logic       neg;
    tok_state_t st;
  } tok_status_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Status update for one non-colon character; overflow is handled by the caller.
  function automatic tok_status_t commit_status(input tok_status_t ts, input logic [7:0] c);
    tok_status_t ns;
    logic        dig;
    ns  = ts;
    dig = is_digit(c);
    if (!ts.nonempty && (c == CH_STAR)) begin
      ns.lone = LONE_STAR;
    end else if (!ts.nonempty && (c == CH_HASH)) begin
      ns.lone = LONE_HASH;
    end else begin
      ns.lone = LONE_NONE;
    end
    ns.nonempty = 1'b1;
    if ((ts.st == TK_LEAD) && !dig) begin
      if (is_ws(c)) begin
        ns.st = TK_LEAD;
      end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
        ns.st = TK_SIGN;
        if (c == CH_MINUS) begin
          ns.neg = 1'b1;
        end
      end else begin
        ns.st = TK_BAD;
      end
    end else if (ts.st != TK_BAD) begin
      ns.st = dig ? TK_DIGITS : TK_BAD;
    end
    return ns;
  endfunction

  // Verdict on a finished token.
  function automatic err_t judge_code(input tok_status_t s, input logic allow_lone,
                                      input err_t bad_code);
    err_t code;
    if (!s.nonempty) begin
      code = ERR_NONE;
    end else if (allow_lone && (s.lone != LONE_NONE)) begin
      code = ERR_NONE;
    end else if (s.ovf) begin
      code = ERR_OVERFLOW;
    end else if (s.st != TK_DIGITS) begin
      code = bad_code;
    end else begin
      code = ERR_NONE;
    end
    return code;
  endfunction

  // True when the token carries a numeric value.
  function automatic logic judge_set(input tok_status_t s, input logic allow_lone);
    return s.nonempty && !(allow_lone && (s.lone != LONE_NONE)) && !s.ovf &&
           (s.st == TK_DIGITS);
  endfunction

endpackage

FILE: hdl/ssp_if.sv
// ----------------------------------------------------------------------------
// Slice spec parser channels
// Valid/ready channels for the character stream and the parse results.
// ----------------------------------------------------------------------------
interface ssp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface ssp_out_if;
  logic               valid;
  logic               ready;
  logic               lower_set;
  logic signed [31:0] lower_value;
  logic               upper_set;
  logic signed [31:0] upper_value;
  logic               stride_set;
  logic signed [31:0] stride_value;
  logic               range_form;
  logic [2:0]         error_code;

  modport source (output valid, output lower_set, output lower_value, output upper_set,
                  output upper_value, output stride_set, output stride_value,
                  output range_form, output error_code, input ready);
  modport sink   (input valid, input lower_set, input lower_value, input upper_set,
                  input upper_value, input stride_set, input stride_value,
                  input range_form, input error_code, output ready);
endinterface

FILE: hdl/slice_spec_parser.sv
// ----------------------------------------------------------------------------
// Slice spec parser
// Parses the text of one slice dimension into lower, upper and stride bounds.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one character per transaction; last_char marks the final
//   character of a dimension's text. out_ch carries one result per text.
//   Each accepted character updates the trim and token state in the cycle it
//   arrives, including the multiply-by-ten accumulate of a digit. The final
//   character also latches the three finished tokens into a pending stage;
//   it is judged and loads the output register once that register is empty
//   or being read. Throughput: one character per cycle while in_ch.ready is
//   high. Results pass from the pending stage to the output register. When
//   out_ch stalls, one result waits in the output register and one more in
//   the pending stage; in_ready drops only when both are full. Reset clears
//   all parse state and empties both stages. No clearing pass.
// ----------------------------------------------------------------------------
`include "slice_spec_parser_defines.svh"

module slice_spec_parser #(
  parameter int VALUE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  ssp_in_if.sink           in_ch,
  ssp_out_if.source        out_ch
);
  import ssp_pkg::*;

  localparam int WB = (VALUE_BITS > OUT_VALUE_BITS) ? VALUE_BITS : OUT_VALUE_BITS;
  localparam int PB = VALUE_BITS + 4;
  localparam logic [PB-1:0]         HALF    = PB'(1) << (VALUE_BITS - 1);
  localparam logic [VALUE_BITS-1:0] MAG_TOP = {1'b0, {(VALUE_BITS-1){1'b1}}};

  // Parse state
  phase_t                  phase_r, phase_nxt;
  logic                    held_ws_r, held_ws_nxt;
  logic                    held_br_r, held_br_nxt;
  tok_status_t             ts_r, ts_nxt;
  logic [VALUE_BITS-1:0]   acc_r, acc_nxt;
  logic [1:0]              colon_r, colon_nxt;
  tok_status_t             slot_st_r  [3];
  logic [VALUE_BITS-1:0]   slot_mag_r [3];
  tok_status_t             slot_st_nxt  [3];
  logic [VALUE_BITS-1:0]   slot_mag_nxt [3];

  // Pending stage
  logic                    fin_valid_r;
  tok_status_t             fin_st_r  [3];
  logic [VALUE_BITS-1:0]   fin_mag_r [3];
  logic [1:0]              fin_colon_r;

  // Output register
  logic                    out_valid_r;
  logic                    lower_set_r, upper_set_r, stride_set_r, range_form_r;
  logic [31:0]             lower_value_r, upper_value_r, stride_value_r;
  err_t                    error_code_r;

  logic       in_acc, out_load;
  logic [7:0] c;

  assign c        = in_ch.char_code;
  assign out_load = fin_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !fin_valid_r || out_load;
  assign in_acc   = in_ch.valid && in_ch.ready;

  // Decimal accumulate and range check; the digit value is the low nibble.
  logic [PB-1:0] prod, lim;
  logic          ovf_now;
  assign prod    = (PB'(acc_r) << 3) + (PB'(acc_r) << 1) + PB'(c[3:0]);
  assign lim     = ts_r.neg ? HALF : (HALF - PB'(1));
  assign ovf_now = prod > lim;

  always_comb begin
    logic       core;
    tok_state_t st_pre;
    phase_nxt   = phase_r;
    held_ws_nxt = held_ws_r;
    held_br_nxt = held_br_r;
    ts_nxt      = ts_r;
    acc_nxt     = acc_r;
    colon_nxt   = colon_r;
    for (int i = 0; i < 3; i++) begin
      slot_st_nxt[i]  = slot_st_r[i];
      slot_mag_nxt[i] = slot_mag_r[i];
    end
    core   = 1'b1;
    st_pre = TK_LEAD;
    unique case (phase_r)
      PH_BRACKET: begin
        if (c == CH_LBR) begin
          core = 1'b0;
        end else if (is_ws(c)) begin
          phase_nxt = PH_SPACE;
          core      = 1'b0;
        end
      end
      PH_SPACE: begin
        if (is_ws(c)) begin
          core = 1'b0;
        end
      end
      PH_CORE: begin
      end
      default: begin
      end
    endcase
    if (core) begin
      phase_nxt = PH_CORE;
      if (is_ws(c)) begin
        // Whitespace after a held ']' makes the ']' part of the core.
        if (held_br_r) begin
          if (held_ws_r) begin
            ts_nxt = commit_status(ts_nxt, CH_SPACE);
          end
          ts_nxt      = commit_status(ts_nxt, CH_RBR);
          held_br_nxt = 1'b0;
        end
        held_ws_nxt = 1'b1;
      end else if (c == CH_RBR) begin
        held_br_nxt = 1'b1;
      end else begin
        if (held_ws_r) begin
          ts_nxt = commit_status(ts_nxt, CH_SPACE);
        end
        if (held_br_r) begin
          ts_nxt = commit_status(ts_nxt, CH_RBR);
        end
        held_ws_nxt = 1'b0;
        held_br_nxt = 1'b0;
        if (c == CH_COLON) begin
          for (int i = 0; i < 3; i++) begin
            if (colon_r == 2'(i)) begin
              slot_st_nxt[i]  = ts_nxt;
              slot_mag_nxt[i] = acc_r;
            end
          end
          ts_nxt  = '0;
          acc_nxt = '0;
          if (colon_r != 2'd3) begin
            colon_nxt = colon_r + 2'd1;
          end
        end else begin
          st_pre = ts_nxt.st;
          ts_nxt = commit_status(ts_nxt, c);
          if (is_digit(c) && (st_pre != TK_BAD) && !ts_nxt.ovf) begin
            if (ovf_now) begin
              ts_nxt.ovf = 1'b1;
            end else begin
              acc_nxt = prod[VALUE_BITS-1:0];
            end
          end
        end
      end
    end
    if (in_ch.last_char) begin
      // Drop any held tail, finish the open token.
      for (int i = 0; i < 3; i++) begin
        if (colon_nxt == 2'(i)) begin
          slot_st_nxt[i]  = ts_nxt;
          slot_mag_nxt[i] = acc_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_BRACKET;
      held_ws_r <= 1'b0;
      held_br_r <= 1'b0;
      ts_r      <= '0;
      acc_r     <= '0;
      colon_r   <= '0;
      for (int i = 0; i < 3; i++) begin
        slot_st_r[i]  <= '0;
        slot_mag_r[i] <= '0;
      end
    end else if (in_acc) begin
      if (in_ch.last_char) begin
        phase_r   <= PH_BRACKET;
        held_ws_r <= 1'b0;
        held_br_r <= 1'b0;
        ts_r      <= '0;
        acc_r     <= '0;
        colon_r   <= '0;
        for (int i = 0; i < 3; i++) begin
          slot_st_r[i]  <= '0;
          slot_mag_r[i] <= '0;
        end
      end else begin
        phase_r   <= phase_nxt;
        held_ws_r <= held_ws_nxt;
        held_br_r <= held_br_nxt;
        ts_r      <= ts_nxt;
        acc_r     <= acc_nxt;
        colon_r   <= colon_nxt;
        for (int i = 0; i < 3; i++) begin
          slot_st_r[i]  <= slot_st_nxt[i];
          slot_mag_r[i] <= slot_mag_nxt[i];
        end
      end
    end
  end

  // Pending stage: finished tokens of one text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (in_acc && in_ch.last_char) begin
      fin_valid_r <= 1'b1;
    end else if (out_load) begin
      fin_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.last_char) begin
      fin_colon_r <= colon_nxt;
      for (int i = 0; i < 3; i++) begin
        fin_st_r[i]  <= slot_st_nxt[i];
        fin_mag_r[i] <= slot_mag_nxt[i];
      end
    end
  end

  // Signed token values, widened so the low 32 bits match a 64-bit view
  logic signed [VALUE_BITS-1:0] sval [3];
  logic signed [WB-1:0]         wval [3];
  logic        [WB-1:0]         wval_inc;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sval[i] = fin_st_r[i].neg ? -$signed(fin_mag_r[i]) : $signed(fin_mag_r[i]);
      wval[i] = WB'(sval[i]);
    end
    wval_inc = wval[0] + WB'(1);
  end

  err_t        res_code;
  logic        res_lo_set, res_up_set, res_st_set;
  logic [31:0] res_lo_val, res_up_val, res_st_val;
  always_comb begin
    res_code   = ERR_NONE;
    res_lo_set = 1'b0;
    res_up_set = 1'b0;
    res_st_set = 1'b0;
    res_lo_val = '0;
    res_up_val = '0;
    res_st_val = '0;
    if (fin_colon_r == 2'd3) begin
      res_code = ERR_COLONS;
    end else if (fin_colon_r != 2'd0) begin
      res_code   = judge_code(fin_st_r[0], 1'b1, ERR_LOWER);
      res_lo_set = judge_set(fin_st_r[0], 1'b1);
      res_lo_val = res_lo_set ? wval[0][31:0] : '0;
      if (res_code == ERR_NONE) begin
        res_code   = judge_code(fin_st_r[1], 1'b1, ERR_UPPER);
        res_up_set = judge_set(fin_st_r[1], 1'b1);
        res_up_val = res_up_set ? wval[1][31:0] : '0;
      end
      if ((res_code == ERR_NONE) && (fin_colon_r == 2'd2)) begin
        res_code   = judge_code(fin_st_r[2], 1'b0, ERR_STRIDE);
        res_st_set = judge_set(fin_st_r[2], 1'b0);
        res_st_val = res_st_set ? wval[2][31:0] : '0;
      end
    end else begin
      if (fin_st_r[0].lone == LONE_STAR) begin
        res_lo_set = 1'b1;
      end else if (fin_st_r[0].lone == LONE_HASH) begin
        res_lo_set = 1'b1;
        res_lo_val = '1;
      end else if (!fin_st_r[0].nonempty) begin
        res_code = ERR_SINGLE;
      end else begin
        res_code   = judge_code(fin_st_r[0], 1'b0, ERR_SINGLE);
        res_lo_set = 1'b1;
        res_lo_val = wval[0][31:0];
        // n+1 must fit in the value range
        if (res_code == ERR_NONE) begin
          if (!fin_st_r[0].neg && (fin_mag_r[0] == MAG_TOP)) begin
            res_code = ERR_OVERFLOW;
          end else begin
            res_up_set = 1'b1;
            res_up_val = wval_inc[31:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      error_code_r <= res_code;
      if (res_code == ERR_NONE) begin
        range_form_r   <= 1'b1;
        lower_set_r    <= res_lo_set;
        lower_value_r  <= res_lo_val;
        upper_set_r    <= res_up_set;
        upper_value_r  <= res_up_val;
        stride_set_r   <= res_st_set;
        stride_value_r <= res_st_val;
      end else begin
        // Any fault zeroes every other field
        range_form_r   <= 1'b0;
        lower_set_r    <= 1'b0;
        lower_value_r  <= '0;
        upper_set_r    <= 1'b0;
        upper_value_r  <= '0;
        stride_set_r   <= 1'b0;
        stride_value_r <= '0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.lower_set    = lower_set_r;
  assign out_ch.lower_value  = lower_value_r;
  assign out_ch.upper_set    = upper_set_r;
  assign out_ch.upper_value  = upper_value_r;
  assign out_ch.stride_set   = stride_set_r;
  assign out_ch.stride_value = stride_value_r;
  assign out_ch.range_form   = range_form_r;
  assign out_ch.error_code   = error_code_r;

  logic out_fault, out_clean, out_any_set, last_acc, pend_stall;
  assign out_fault   = out_ch.valid && (out_ch.error_code != ERR_NONE);
  assign out_clean   = out_ch.valid && (out_ch.error_code == ERR_NONE);
  assign out_any_set = out_ch.range_form || out_ch.lower_set || out_ch.upper_set ||
                       out_ch.stride_set;
  assign last_acc    = in_acc && in_ch.last_char;
  assign pend_stall  = fin_valid_r && !out_load;

  `SSP_ASSERT_NOW(a_fault_zeroes, out_fault, !out_any_set, "fault result carries set fields")
  `SSP_ASSERT_NOW(a_ok_is_range, out_clean, out_ch.range_form, "clean result without range form")
  `SSP_ASSERT_NEXT(a_last_pends, last_acc, fin_valid_r, "final character not latched")
  `SSP_ASSERT_NEXT(a_pend_held, pend_stall, fin_valid_r && $stable(fin_colon_r), "pending dropped")

endmodule
